/* hw/rtl/mgb_pkg.sv */
// Shared types and constants for the monochrome glyph blitter.
// Holds store sizing, register indexes, command and status codes, and port structs.
// No dependencies.
package mgb_pkg;

	localparam int STORE_BYTES = 8192;
	localparam int MAX_WIDTH = 16;
	localparam int MAX_ROWS = 32;
	localparam int MAX_SCREEN = 1024;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int Y_W = $clog2(MAX_ROWS);
	localparam int PY_W = $clog2(MAX_SCREEN);
	localparam int BASE_W = 24;
	localparam int MASK_W = 16;
	localparam int BYTE_W = 8;
	localparam int ROWB_W = 20;
	localparam int TOTAL_W = 10;
	localparam int CIDX_W = 3;
	localparam int CDATA_W = 14;

	localparam logic [CIDX_W-1:0] REG_GLYPH_COUNT = 3'd0;
	localparam logic [CIDX_W-1:0] REG_GLYPH_WIDTH = 3'd1;
	localparam logic [CIDX_W-1:0] REG_GLYPH_HEIGHT = 3'd2;
	localparam logic [CIDX_W-1:0] REG_GLYPH_BYTES = 3'd3;
	localparam logic [CIDX_W-1:0] REG_SCREEN_WIDTH = 3'd4;
	localparam logic [CIDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
	localparam logic [CIDX_W-1:0] REG_SCREEN_STRIDE = 3'd6;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	localparam logic ST_OK = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		logic [9:0]  glyph_count;
		logic [4:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [13:0] glyph_bytes;
		logic [10:0] screen_width;
		logic [10:0] screen_height;
		logic [10:0] screen_stride;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		glyph_count:   10'd256,
		glyph_width:   5'd16,
		glyph_height:  6'd16,
		glyph_bytes:   14'd32,
		screen_width:  11'd320,
		screen_height: 11'd200,
		screen_stride: 11'd320
	};

	typedef struct packed {
		logic [8:0]  glyph_index;
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [7:0]  fore_color;
		logic [8:0]  back_color;
	} draw_req_t;

	typedef struct packed {
		logic               status;
		logic [ROWB_W-1:0]  row_base;
		logic [11:0]        span_x;
		logic [MASK_W-1:0]  write_mask;
		logic [MASK_W-1:0]  fore_mask;
		logic [BYTE_W-1:0]  fore_value;
		logic [BYTE_W-1:0]  back_value;
		logic [TOTAL_W-1:0] write_total;
		logic               last;
	} res_t;

endpackage

/* hw/rtl/mgb_store.sv */
// Glyph bitmap store: one write port, one read port with registered read data.
// Depends on mgb_pkg for store depth and address width.
module mgb_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [mgb_pkg::AW-1:0]     wr_addr,
	input  logic [mgb_pkg::BYTE_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [mgb_pkg::AW-1:0]     rd_addr,
	output logic [mgb_pkg::BYTE_W-1:0] rd_data
);

	logic [mgb_pkg::BYTE_W-1:0] mem_q [mgb_pkg::STORE_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/mgb_seq.sv */
// Draw sequencer: checks the layout, walks visible glyph rows through the store,
// builds masks and holds the result register. Depends on mgb_pkg.
module mgb_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mgb_pkg::cfg_t             cfg,
	input  logic                      start,
	input  mgb_pkg::draw_req_t        req,
	output logic                      busy,
	output logic                      rd_en,
	output logic [mgb_pkg::AW-1:0]     rd_addr,
	input  logic [mgb_pkg::BYTE_W-1:0] rd_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output mgb_pkg::res_t             res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_MUL,
		S_RD0,
		S_RD1,
		S_ROW,
		S_FIN
	} state_t;

	function automatic logic [4:0] popcount16(input logic [15:0] v);
		logic [2:0] n0, n1, n2, n3;
		n0 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
		n1 = 3'(v[4]) + 3'(v[5]) + 3'(v[6]) + 3'(v[7]);
		n2 = 3'(v[8]) + 3'(v[9]) + 3'(v[10]) + 3'(v[11]);
		n3 = 3'(v[12]) + 3'(v[13]) + 3'(v[14]) + 3'(v[15]);
		return 5'(n0) + 5'(n1) + 5'(n2) + 5'(n3);
	endfunction

	state_t                              state_q;
	logic [11:0]                         ox_q;
	logic [11:0]                         oy_q;
	logic [7:0]                          fv_q;
	logic [8:0]                          back_q;
	logic [8:0]                          idx_q;
	logic [mgb_pkg::BASE_W-1:0]          base_q;
	logic [1:0]                          rb_q;
	logic                                reject_q;
	logic [mgb_pkg::Y_W-1:0]             y_q;
	logic [mgb_pkg::Y_W-1:0]             y_hi_q;
	logic [mgb_pkg::PY_W-1:0]            py_q;
	logic [mgb_pkg::AW-1:0]              row_addr_q;
	logic [mgb_pkg::MASK_W-1:0]          colvis_q;
	logic [mgb_pkg::BYTE_W-1:0]          byte0_q;
	logic [mgb_pkg::ROWB_W-1:0]          row_base_q;
	logic [mgb_pkg::TOTAL_W-1:0]         total_q;
	mgb_pkg::res_t                       res_q;
	logic                                out_valid_q;

	logic [2:0]                          rb_full;
	logic [8:0]                          need;
	logic                                bad;
	logic signed [13:0]                  oy_w;
	logic signed [13:0]                  lo_w;
	logic signed [13:0]                  hi_a;
	logic signed [13:0]                  hi_b;
	logic signed [13:0]                  hi_w;
	logic                                empty;
	logic signed [13:0]                  px_w [mgb_pkg::MASK_W];
	logic [mgb_pkg::MASK_W-1:0]          colvis;
	logic [2*mgb_pkg::BYTE_W-1:0]        row_bits;
	logic [mgb_pkg::MASK_W-1:0]          pix;
	logic [mgb_pkg::MASK_W-1:0]          fm;
	logic [mgb_pkg::MASK_W-1:0]          wm;
	logic [4:0]                          cnt;
	logic [mgb_pkg::TOTAL_W-1:0]         total_new;
	logic                                out_free;
	logic                                emit;
	logic [mgb_pkg::BYTE_W-1:0]          back_byte;
	mgb_pkg::res_t                       row_res;
	mgb_pkg::res_t                       fin_res;

	always_comb begin
		rb_full = 3'((6'(cfg.glyph_width) + 6'd7) >> 3);
		need = 9'(rb_full) * 9'(cfg.glyph_height);
		bad = (cfg.screen_width == '0) || (cfg.screen_height == '0) ||
			(cfg.screen_stride < cfg.screen_width) ||
			(32'(cfg.screen_width) > 32'(mgb_pkg::MAX_SCREEN)) ||
			(32'(cfg.screen_height) > 32'(mgb_pkg::MAX_SCREEN)) ||
			(32'(cfg.screen_stride) > 32'(mgb_pkg::MAX_SCREEN)) ||
			(cfg.glyph_count == '0) || (cfg.glyph_width == '0) ||
			(cfg.glyph_height == '0) || (cfg.glyph_bytes == '0) ||
			(32'(cfg.glyph_width) > 32'(mgb_pkg::MAX_WIDTH)) ||
			(32'(cfg.glyph_height) > 32'(mgb_pkg::MAX_ROWS)) ||
			(10'(idx_q) >= cfg.glyph_count) ||
			(cfg.glyph_bytes < 14'(need)) ||
			((32'(base_q) + 32'(need)) > 32'(mgb_pkg::STORE_BYTES));

		oy_w = 14'($signed(oy_q));
		lo_w = (oy_w < 14'sd0) ? -oy_w : 14'sd0;
		hi_a = $signed(14'(cfg.glyph_height)) - 14'sd1;
		hi_b = $signed(14'(cfg.screen_height)) - 14'sd1 - oy_w;
		hi_w = (hi_a < hi_b) ? hi_a : hi_b;
		empty = lo_w > hi_w;

		for (int x = 0; x < mgb_pkg::MASK_W; x++) begin
			px_w[x] = 14'($signed(ox_q)) + 14'(x);
			colvis[x] = (px_w[x] >= 14'sd0) &&
				(px_w[x] < $signed({3'b000, cfg.screen_width})) &&
				(5'(x) < cfg.glyph_width);
		end
	end

	always_comb begin
		row_bits = {byte0_q, rd_data};
		for (int x = 0; x < mgb_pkg::MASK_W; x++) begin
			pix[x] = row_bits[mgb_pkg::MASK_W-1-x];
		end
		fm = pix & colvis_q;
		wm = back_q[8] ? fm : colvis_q;
		cnt = popcount16(wm);
		total_new = total_q + mgb_pkg::TOTAL_W'(cnt);
		out_free = !out_valid_q || !out_stall;
		emit = out_free && ((state_q == S_ROW) || (state_q == S_FIN));
		back_byte = back_q[8] ? '0 : back_q[7:0];

		row_res.status = mgb_pkg::ST_OK;
		row_res.row_base = row_base_q;
		row_res.span_x = ox_q;
		row_res.write_mask = wm;
		row_res.fore_mask = fm;
		row_res.fore_value = fv_q;
		row_res.back_value = back_byte;
		row_res.write_total = total_new;
		row_res.last = (y_q == y_hi_q);

		fin_res = '0;
		fin_res.last = 1'b1;
		if (reject_q) begin
			fin_res.status = mgb_pkg::ST_REJECT;
		end else begin
			fin_res.status = mgb_pkg::ST_OK;
			fin_res.span_x = ox_q;
			fin_res.fore_value = fv_q;
			fin_res.back_value = back_byte;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign rd_en = (state_q == S_RD0) || (state_q == S_RD1);
	assign rd_addr = (state_q == S_RD1) ? row_addr_q + mgb_pkg::AW'(1) : row_addr_q;
	assign out_valid = out_valid_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			res_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			fv_q <= '0;
			back_q <= '0;
			idx_q <= '0;
			base_q <= '0;
			rb_q <= '0;
			reject_q <= 1'b0;
			y_q <= '0;
			y_hi_q <= '0;
			py_q <= '0;
			row_addr_q <= '0;
			colvis_q <= '0;
			byte0_q <= '0;
			row_base_q <= '0;
			total_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q <= req.glyph_index;
						ox_q <= req.origin_x;
						oy_q <= req.origin_y;
						fv_q <= req.fore_color;
						back_q <= req.back_color;
						base_q <= mgb_pkg::BASE_W'(req.glyph_index) *
							mgb_pkg::BASE_W'(cfg.glyph_bytes);
						total_q <= '0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					reject_q <= bad;
					rb_q <= 2'(rb_full);
					y_q <= mgb_pkg::Y_W'(lo_w);
					y_hi_q <= mgb_pkg::Y_W'(hi_w);
					py_q <= mgb_pkg::PY_W'(oy_w + lo_w);
					row_addr_q <= mgb_pkg::AW'(base_q) +
						mgb_pkg::AW'(mgb_pkg::AW'(lo_w[mgb_pkg::Y_W-1:0]) *
						mgb_pkg::AW'(rb_full[1:0]));
					colvis_q <= colvis;
					state_q <= (bad || empty) ? S_FIN : S_MUL;
				end
				S_MUL: begin
					row_base_q <= mgb_pkg::ROWB_W'(py_q) * mgb_pkg::ROWB_W'(cfg.screen_stride);
					state_q <= S_RD0;
				end
				S_RD0: begin
					state_q <= S_RD1;
				end
				S_RD1: begin
					byte0_q <= rd_data;
					state_q <= S_ROW;
				end
				S_ROW: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q <= row_res;
						total_q <= total_new;
						if (y_q == y_hi_q) begin
							state_q <= S_IDLE;
						end else begin
							y_q <= y_q + mgb_pkg::Y_W'(1);
							row_addr_q <= row_addr_q + mgb_pkg::AW'(rb_q);
							row_base_q <= row_base_q + mgb_pkg::ROWB_W'(cfg.screen_stride);
							state_q <= S_RD0;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q <= fin_res;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/mono_glyph_blitter_top.sv */
// Monochrome glyph blitter top level: a load writes the store and the block stays ready.
// A draw steps through setup and a row-base multiply, then for each visible row two byte reads
// on the single store read port plus emit; a rejected or fully hidden draw goes from setup to emit.
// The first row result is registered after the setup, multiply and two read states, once the output
// register is free; results wait in an output register while the next stage stalls.
// Reset clears control state and registers to defaults; the glyph store is undefined until loaded.
module mono_glyph_blitter_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [12:0] load_address,
	input  logic [7:0]  load_byte,
	input  logic [8:0]  glyph_index,
	input  logic [11:0] origin_x,
	input  logic [11:0] origin_y,
	input  logic [7:0]  fore_color,
	input  logic [8:0]  back_color,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [19:0] row_base,
	output logic [11:0] span_x,
	output logic [15:0] write_mask,
	output logic [15:0] fore_mask,
	output logic [7:0]  fore_value,
	output logic [7:0]  back_value,
	output logic [9:0]  write_total,
	output logic        last
);

	mgb_pkg::cfg_t              cfg_q;
	mgb_pkg::draw_req_t         req;
	mgb_pkg::res_t              res;
	logic                       busy;
	logic                       in_acc;
	logic                       draw_start;
	logic                       wr_en;
	logic [mgb_pkg::AW-1:0]     wr_addr;
	logic                       rd_en;
	logic [mgb_pkg::AW-1:0]     rd_addr;
	logic [mgb_pkg::BYTE_W-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign in_stall = busy;
	assign in_acc = in_valid && !in_stall;
	assign draw_start = in_acc && (command == mgb_pkg::CMD_DRAW);
	assign wr_en = in_acc && (command == mgb_pkg::CMD_LOAD) &&
		(32'(load_address) < 32'(mgb_pkg::STORE_BYTES));
	assign wr_addr = mgb_pkg::AW'(load_address);

	assign req.glyph_index = glyph_index;
	assign req.origin_x = origin_x;
	assign req.origin_y = origin_y;
	assign req.fore_color = fore_color;
	assign req.back_color = back_color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mgb_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mgb_pkg::REG_GLYPH_COUNT:   cfg_q.glyph_count <= cfg_data[9:0];
				mgb_pkg::REG_GLYPH_WIDTH:   cfg_q.glyph_width <= cfg_data[4:0];
				mgb_pkg::REG_GLYPH_HEIGHT:  cfg_q.glyph_height <= cfg_data[5:0];
				mgb_pkg::REG_GLYPH_BYTES:   cfg_q.glyph_bytes <= cfg_data[13:0];
				mgb_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width <= cfg_data[10:0];
				mgb_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[10:0];
				mgb_pkg::REG_SCREEN_STRIDE: cfg_q.screen_stride <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	mgb_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (load_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mgb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (draw_start),
		.req       (req),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res       (res)
	);

	assign status = res.status;
	assign row_base = res.row_base;
	assign span_x = res.span_x;
	assign write_mask = res.write_mask;
	assign fore_mask = res.fore_mask;
	assign fore_value = res.fore_value;
	assign back_value = res.back_value;
	assign write_total = res.write_total;
	assign last = res.last;

	a_draw_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		draw_start |=> in_stall)
		else $error("input not held after draw transaction");

	a_load_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (command == mgb_pkg::CMD_LOAD)) |=> !in_stall)
		else $error("load transaction left the block busy");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == mgb_pkg::ST_REJECT)) |->
		(last && (write_mask == '0) && (write_total == '0)))
		else $error("rejected result carries data");

	a_fore_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((fore_mask & ~write_mask) == '0))
		else $error("foreground pixel outside write mask");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
		(!out_valid || (write_total >= $past(write_total))))
		else $error("write total decreased within a draw");

endmodule

/* tb/sv/tb_mono_glyph_blitter_top.sv */
// Self-checking testbench for mono_glyph_blitter_top: glyph loads and clipped draws
// checked row by row against an in-bench predictor of the blitter. Depends on mgb_pkg.
`timescale 1ns / 100ps

module tb_mono_glyph_blitter_top;

	localparam int QUIET_CYCLES = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 16;
	localparam int FILL_BYTES = 128;

	typedef struct packed {
		logic                       command;
		logic [mgb_pkg::AW-1:0]     load_address;
		logic [mgb_pkg::BYTE_W-1:0] load_byte;
		mgb_pkg::draw_req_t         draw;
	} txn_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [13:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [12:0] load_address;
	logic [7:0]  load_byte;
	logic [8:0]  glyph_index;
	logic [11:0] origin_x;
	logic [11:0] origin_y;
	logic [7:0]  fore_color;
	logic [8:0]  back_color;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [19:0] row_base;
	logic [11:0] span_x;
	logic [15:0] write_mask;
	logic [15:0] fore_mask;
	logic [7:0]  fore_value;
	logic [7:0]  back_value;
	logic [9:0]  write_total;
	logic        last;

	logic [7:0]    font_mem [mgb_pkg::STORE_BYTES];
	mgb_pkg::cfg_t cur_cfg = mgb_pkg::CFG_RESET;
	mgb_pkg::res_t row_expect [$];
	mgb_pkg::res_t exp_row;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int err_count = 0;
	int txn_count = 0;
	int draw_count = 0;
	int rows_checked = 0;
	int cfg_count = 0;

	mono_glyph_blitter_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.load_address (load_address),
		.load_byte    (load_byte),
		.glyph_index  (glyph_index),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.fore_color   (fore_color),
		.back_color   (back_color),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.row_base     (row_base),
		.span_x       (span_x),
		.write_mask   (write_mask),
		.fore_mask    (fore_mask),
		.fore_value   (fore_value),
		.back_value   (back_value),
		.write_total  (write_total),
		.last         (last)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void predict_rows(input txn_t t);
		int ox, oy, back, py, px, x, y, nrows;
		int unsigned row_bytes, need, base, addr, total;
		logic [15:0] wm, fm;
		logic opaque, reject;
		mgb_pkg::res_t r;
		if (t.command == mgb_pkg::CMD_LOAD) begin
			font_mem[t.load_address] = t.load_byte;
			return;
		end
		ox = $signed(t.draw.origin_x);
		oy = $signed(t.draw.origin_y);
		back = $signed(t.draw.back_color);
		opaque = (back >= 0);
		row_bytes = (cur_cfg.glyph_width + 7) / 8;
		need = row_bytes * cur_cfg.glyph_height;
		base = t.draw.glyph_index * cur_cfg.glyph_bytes;
		reject = cur_cfg.screen_width == 0 || cur_cfg.screen_height == 0 ||
			cur_cfg.screen_stride < cur_cfg.screen_width ||
			cur_cfg.screen_width > mgb_pkg::MAX_SCREEN ||
			cur_cfg.screen_height > mgb_pkg::MAX_SCREEN ||
			cur_cfg.screen_stride > mgb_pkg::MAX_SCREEN ||
			cur_cfg.glyph_count == 0 || cur_cfg.glyph_width == 0 ||
			cur_cfg.glyph_height == 0 || cur_cfg.glyph_bytes == 0 ||
			cur_cfg.glyph_width > mgb_pkg::MAX_WIDTH ||
			cur_cfg.glyph_height > mgb_pkg::MAX_ROWS ||
			t.draw.glyph_index >= cur_cfg.glyph_count ||
			cur_cfg.glyph_bytes < need || base + need > mgb_pkg::STORE_BYTES;
		r = '0;
		if (reject) begin
			r.status = mgb_pkg::ST_REJECT;
			r.last = 1'b1;
			row_expect.push_back(r);
			return;
		end
		r.status = mgb_pkg::ST_OK;
		r.span_x = t.draw.origin_x;
		r.fore_value = t.draw.fore_color;
		r.back_value = opaque ? t.draw.back_color[7:0] : 8'd0;
		total = 0;
		nrows = 0;
		for (y = 0; y < int'(cur_cfg.glyph_height); y++) begin
			py = oy + y;
			if (py < 0 || py >= int'(cur_cfg.screen_height))
				continue;
			wm = '0;
			fm = '0;
			for (x = 0; x < int'(cur_cfg.glyph_width); x++) begin
				px = ox + x;
				if (px < 0 || px >= int'(cur_cfg.screen_width))
					continue;
				addr = base + y * row_bytes + x / 8;
				if (font_mem[addr][7 - x % 8]) begin
					wm[x] = 1'b1;
					fm[x] = 1'b1;
					total++;
				end else if (opaque) begin
					wm[x] = 1'b1;
					total++;
				end
			end
			r.row_base = 20'(py * int'(cur_cfg.screen_stride));
			r.write_mask = wm;
			r.fore_mask = fm;
			r.write_total = 10'(total);
			r.last = 1'b0;
			row_expect.push_back(r);
			nrows++;
		end
		if (nrows == 0) begin
			r.row_base = '0;
			r.write_mask = '0;
			r.fore_mask = '0;
			r.write_total = '0;
			r.last = 1'b1;
			row_expect.push_back(r);
		end else begin
			row_expect[row_expect.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic mgb_pkg::cfg_t make_cfg(input int gc, input int gw, input int gh,
			input int gb, input int sw, input int sh, input int ss);
		mgb_pkg::cfg_t c;
		c.glyph_count = gc[9:0];
		c.glyph_width = gw[4:0];
		c.glyph_height = gh[5:0];
		c.glyph_bytes = gb[13:0];
		c.screen_width = sw[10:0];
		c.screen_height = sh[10:0];
		c.screen_stride = ss[10:0];
		return c;
	endfunction

	function automatic mgb_pkg::cfg_t rand_cfg();
		int gw, gh, need, gb, gc_max, sw, sh;
		gw = $urandom_range(1, mgb_pkg::MAX_WIDTH);
		gh = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) :
			$urandom_range(1, mgb_pkg::MAX_ROWS);
		need = ((gw + 7) / 8) * gh;
		gb = need + int'($urandom_range(0, 6));
		gc_max = mgb_pkg::STORE_BYTES / gb;
		if (gc_max > 512)
			gc_max = 512;
		sw = $urandom_range(0, 1) ? $urandom_range(1, 48) :
			$urandom_range(1, mgb_pkg::MAX_SCREEN);
		sh = $urandom_range(0, 1) ? $urandom_range(1, 48) :
			$urandom_range(1, mgb_pkg::MAX_SCREEN);
		return make_cfg($urandom_range(1, gc_max), gw, gh, gb, sw, sh,
			$urandom_range(sw, mgb_pkg::MAX_SCREEN));
	endfunction

	function automatic txn_t load_txn(input int addr, input int value);
		txn_t t;
		t = '0;
		t.command = mgb_pkg::CMD_LOAD;
		t.load_address = addr[mgb_pkg::AW-1:0];
		t.load_byte = value[7:0];
		return t;
	endfunction

	function automatic txn_t draw_txn(input int idx, input int ox, input int oy,
			input int fg, input int bg);
		txn_t t;
		t = '0;
		t.command = mgb_pkg::CMD_DRAW;
		t.draw.glyph_index = idx[8:0];
		t.draw.origin_x = ox[11:0];
		t.draw.origin_y = oy[11:0];
		t.draw.fore_color = fg[7:0];
		t.draw.back_color = bg[8:0];
		return t;
	endfunction

	// Accepted draws stay inside the loaded part of the store.
	function automatic txn_t rand_txn();
		txn_t t;
		int ox, oy, span, need, idx_hi, idx;
		t.command = ($urandom_range(0, 99) < 25) ? mgb_pkg::CMD_LOAD : mgb_pkg::CMD_DRAW;
		span = int'(cur_cfg.glyph_count) * int'(cur_cfg.glyph_bytes);
		if ($urandom_range(0, 1) && span > 0 && span <= mgb_pkg::STORE_BYTES)
			t.load_address = 13'($urandom_range(0, span - 1));
		else
			t.load_address = 13'($urandom);
		t.load_byte = 8'($urandom);
		need = ((int'(cur_cfg.glyph_width) + 7) / 8) * int'(cur_cfg.glyph_height);
		idx_hi = 0;
		if (cur_cfg.glyph_bytes != 0 && need <= FILL_BYTES)
			idx_hi = (FILL_BYTES - need) / int'(cur_cfg.glyph_bytes);
		if (idx_hi > int'(cur_cfg.glyph_count) - 1)
			idx_hi = int'(cur_cfg.glyph_count) - 1;
		if (idx_hi < 0)
			idx_hi = 0;
		if ($urandom_range(0, 9) == 0 && cur_cfg.glyph_count < 512)
			idx = $urandom_range(cur_cfg.glyph_count, 511);
		else
			idx = $urandom_range(0, idx_hi);
		t.draw.glyph_index = idx[8:0];
		if ($urandom_range(0, 99) < 85) begin
			ox = int'($urandom_range(0, cur_cfg.screen_width + 2 * cur_cfg.glyph_width))
				- int'(cur_cfg.glyph_width);
			oy = int'($urandom_range(0, cur_cfg.screen_height + 2 * cur_cfg.glyph_height))
				- int'(cur_cfg.glyph_height);
		end else begin
			ox = int'($urandom);
			oy = int'($urandom);
		end
		t.draw.origin_x = ox[11:0];
		t.draw.origin_y = oy[11:0];
		t.draw.fore_color = 8'($urandom);
		t.draw.back_color = {($urandom_range(0, 99) < 30), 8'($urandom)};
		return t;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	task automatic send_txn(input txn_t t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= t.command;
		load_address <= t.load_address;
		load_byte <= t.load_byte;
		glyph_index <= t.draw.glyph_index;
		origin_x <= t.draw.origin_x;
		origin_y <= t.draw.origin_y;
		fore_color <= t.draw.fore_color;
		back_color <= t.draw.back_color;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_rows(t);
		txn_count++;
		if (t.command == mgb_pkg::CMD_DRAW)
			draw_count++;
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (row_expect.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input mgb_pkg::cfg_t c);
		int ri;
		logic [mgb_pkg::CIDX_W-1:0] reg_idx;
		logic [13:0] data;
		wait_quiet();
		for (ri = int'(mgb_pkg::REG_GLYPH_COUNT); ri <= int'(mgb_pkg::REG_SCREEN_STRIDE);
				ri++) begin
			reg_idx = ri[mgb_pkg::CIDX_W-1:0];
			case (reg_idx)
				mgb_pkg::REG_GLYPH_COUNT:   data = 14'(c.glyph_count);
				mgb_pkg::REG_GLYPH_WIDTH:   data = 14'(c.glyph_width);
				mgb_pkg::REG_GLYPH_HEIGHT:  data = 14'(c.glyph_height);
				mgb_pkg::REG_GLYPH_BYTES:   data = c.glyph_bytes;
				mgb_pkg::REG_SCREEN_WIDTH:  data = 14'(c.screen_width);
				mgb_pkg::REG_SCREEN_HEIGHT: data = 14'(c.screen_height);
				default:                    data = 14'(c.screen_stride);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx;
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_cfg = c;
		cfg_count++;
	endtask

	task automatic draw_under(input mgb_pkg::cfg_t c, input int idx);
		set_config(c);
		send_txn(draw_txn(idx, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255)));
	endtask

	task automatic test_store_fill();
		int a;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (a = 0; a < FILL_BYTES; a++)
			send_txn(load_txn(a, $urandom_range(0, 255)));
	endtask

	task automatic test_directed();
		send_idle_pct = 13;
		recv_stall_pct = 13;
		send_txn(load_txn(0, 8'hFF));
		send_txn(load_txn(1, 8'h81));
		send_txn(draw_txn(0, 0, 0, 255, 0));
		send_txn(draw_txn(0, 0, 0, 0, -1));
		send_txn(draw_txn(3, 304, 184, 0, 255));
		send_txn(draw_txn(1, 312, 192, 8'h5A, -256));
		send_txn(draw_txn(2, -8, -8, 8'hA5, 8'h3C));
		send_txn(draw_txn(3, 320, 10, 8'h11, 8'h22));
		send_txn(draw_txn(0, -16, 10, 8'h33, -1));
		send_txn(draw_txn(1, 10, 200, 8'h44, 8'h55));
		send_txn(draw_txn(2, 10, -16, 8'h66, 8'h77));
		send_txn(draw_txn(3, -2048, -2048, 255, 255));
		send_txn(draw_txn(0, 2047, 2047, 0, 0));
		send_txn(draw_txn(256, 0, 0, 1, 2));
		send_txn(draw_txn(511, 0, 0, 3, 4));
		send_txn(load_txn(mgb_pkg::STORE_BYTES - 1, 8'hA5));
		send_txn(draw_txn(1, -15, 199, 8'hC3, 255));
	endtask

	task automatic test_backpressure();
		int n;
		wait_quiet();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_seq++;
		for (n = 0; n < 16; n++)
			send_txn(draw_txn($urandom_range(0, 3), $urandom_range(0, 300),
				$urandom_range(0, 180), $urandom_range(0, 255), $urandom_range(0, 511)));
	endtask

	task automatic test_config_rejects();
		send_idle_pct = 0;
		recv_stall_pct = 13;
		draw_under(make_cfg(256, 16, 16, 32, 0, 200, 320), 0);
		draw_under(make_cfg(256, 16, 16, 32, 320, 0, 320), 0);
		draw_under(make_cfg(256, 16, 16, 32, 320, 200, 319), 0);
		draw_under(make_cfg(256, 16, 16, 32, 1025, 200, 1025), 0);
		draw_under(make_cfg(256, 16, 16, 32, 320, 1025, 320), 0);
		draw_under(make_cfg(256, 16, 16, 32, 320, 200, 1025), 0);
		draw_under(make_cfg(0, 16, 16, 32, 320, 200, 320), 0);
		draw_under(make_cfg(256, 0, 16, 32, 320, 200, 320), 0);
		draw_under(make_cfg(256, 16, 0, 32, 320, 200, 320), 0);
		draw_under(make_cfg(256, 16, 16, 0, 320, 200, 320), 0);
		draw_under(make_cfg(256, 17, 16, 48, 320, 200, 320), 0);
		draw_under(make_cfg(256, 16, 33, 66, 320, 200, 320), 0);
		draw_under(make_cfg(256, 9, 4, 7, 320, 200, 320), 0);
		draw_under(make_cfg(256, 9, 4, 8, 320, 200, 320), 1);
		draw_under(make_cfg(512, 16, 16, 32, 320, 200, 320), 3);
		send_txn(draw_txn(256, 0, 0, 9, 9));
	endtask

	task automatic test_random_phases();
		int ph, n;
		mgb_pkg::cfg_t c;
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: c = make_cfg(512, 1, 1, 1, 1, 1, 1);
				1: c = make_cfg(1, 16, 32, 8192, 1024, 1024, 1024);
				2: c = make_cfg(512, 8, 16, 16, 40, 24, 64);
				3: c = make_cfg(512, 9, 8, 16, 17, 9, 1024);
				default: c = rand_cfg();
			endcase
			set_config(c);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 55;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 55;
				end
				default: begin
					send_idle_pct = 13;
					recv_stall_pct = 13;
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++)
				send_txn(rand_txn());
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (row_expect.size() == 0) begin
				$display("%0t: result with nothing expected, row_base %h last %b",
					$time, row_base, last);
				err_count++;
			end else begin
				exp_row = row_expect.pop_front();
				check_field("status", 32'(exp_row.status), 32'(status));
				check_field("row_base", 32'(exp_row.row_base), 32'(row_base));
				check_field("span_x", 32'(exp_row.span_x), 32'(span_x));
				check_field("write_mask", 32'(exp_row.write_mask), 32'(write_mask));
				check_field("fore_mask", 32'(exp_row.fore_mask), 32'(fore_mask));
				check_field("fore_value", 32'(exp_row.fore_value), 32'(fore_value));
				check_field("back_value", 32'(exp_row.back_value), 32'(back_value));
				check_field("write_total", 32'(exp_row.write_total), 32'(write_total));
				check_field("last", 32'(exp_row.last), 32'(last));
				rows_checked++;
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, row_expect.size());
			$display("mono_glyph_blitter_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = mgb_pkg::CMD_LOAD;
		load_address = '0;
		load_byte = '0;
		glyph_index = '0;
		origin_x = '0;
		origin_y = '0;
		fore_color = '0;
		back_color = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_store_fill();
		test_directed();
		test_backpressure();
		test_config_rejects();
		test_random_phases();

		wait_quiet();
		$display("covered %0d transactions (%0d draws), %0d row results, %0d register settings",
			txn_count, draw_count, rows_checked, cfg_count);
		$display("idling none, sender, receiver and both, plus one long receiver hold-off");
		if (err_count == 0) begin
			$display("mono_glyph_blitter_top verification clean");
		end else begin
			$display("%0d mismatches", err_count);
			$display("mono_glyph_blitter_top verification failed");
		end
		$finish;
	end

endmodule

/* mono_glyph_blitter_top.f */
hw/rtl/mgb_pkg.sv
hw/rtl/mgb_store.sv
hw/rtl/mgb_seq.sv
hw/rtl/mono_glyph_blitter_top.sv
tb/sv/tb_mono_glyph_blitter_top.sv
